// ===== hw/rtl/cc20_pkg.sv =====
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and helpers for the ChaCha20 byte stream cipher.
// ----------------------------------------------------------------------------
package cc20_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [3:0] quad_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ROUND,
		S_FINAL
	} state_t;

	// Configuration register indexes
	localparam logic [2:0] REG_KEY_01     = 3'd0;
	localparam logic [2:0] REG_KEY_23     = 3'd1;
	localparam logic [2:0] REG_KEY_45     = 3'd2;
	localparam logic [2:0] REG_KEY_67     = 3'd3;
	localparam logic [2:0] REG_NONCE_LOW  = 3'd4;
	localparam logic [2:0] REG_NONCE_HIGH = 3'd5;
	localparam logic [2:0] REG_NONCE_LONG = 3'd6;

	// "expand 32-byte k"
	localparam word_t SIGMA_0 = 32'h6170_7865;
	localparam word_t SIGMA_1 = 32'h3320_646e;
	localparam word_t SIGMA_2 = 32'h7962_2d32;
	localparam word_t SIGMA_3 = 32'h6b20_6574;

	// Quarter-round sub-steps, each one add, one xor and one rotate
	localparam logic [1:0] SUB_ROT16 = 2'd0;
	localparam logic [1:0] SUB_ROT12 = 2'd1;
	localparam logic [1:0] SUB_ROT8  = 2'd2;
	localparam logic [1:0] SUB_ROT7  = 2'd3;

	// State word index of a lane's operand: row 0..3 is a, b, c, d.
	// Diagonal rounds shift row r left by r columns.
	function automatic logic [3:0] lane_idx(input logic [1:0] row, input logic [1:0] lane,
			input logic diag);
		logic [1:0] col;
		col = lane + (diag ? row : 2'd0);
		return {row, col};
	endfunction

endpackage

// ===== hw/rtl/cc20_step_unit.sv =====
// ----------------------------------------------------------------------------
// cc20_step_unit
// Four-lane add / xor / rotate unit shared by all quarter-round sub-steps
// and by the final feed-forward add.
// ----------------------------------------------------------------------------
module cc20_step_unit (
	input  logic [1:0]     sub,
	input  cc20_pkg::quad_t op_p,
	input  cc20_pkg::quad_t op_q,
	input  cc20_pkg::quad_t op_r,
	output cc20_pkg::quad_t sum,
	output cc20_pkg::quad_t mix
);

	cc20_pkg::quad_t x;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			sum[l] = op_p[l] + op_q[l];
			x[l]   = op_r[l] ^ sum[l];
			case (sub)
				cc20_pkg::SUB_ROT16: mix[l] = {x[l][15:0], x[l][31:16]};
				cc20_pkg::SUB_ROT12: mix[l] = {x[l][19:0], x[l][31:20]};
				cc20_pkg::SUB_ROT8:  mix[l] = {x[l][23:0], x[l][31:24]};
				default:             mix[l] = {x[l][24:0], x[l][31:25]};
			endcase
		end
	end

endmodule

// ===== hw/rtl/chacha20_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 keystream generator that XORs one data byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries data_byte and restart; the
//   output channel (out_valid / out_ready) returns out_byte = data_byte XOR
//   the next keystream byte, one result per request, in order.
//   Key and nonce are written through cfg_we / cfg_index / cfg_data while
//   the block is idle; they take effect at the next keystream block made.
//   A request with restart set clears the block counter and position first.
// Request handling:
//   While the current 64-byte block lasts, a request's result is registered
//   and shown in the cycle after it is taken, and a new request is taken
//   every cycle while the receiver keeps taking results. When a new block
//   is needed (buffer used up or restart), the request waits while the
//   four-lane step unit does one add/xor/rotate sub-step of four quarter
//   rounds per cycle, DOUBLE_ROUNDS double rounds in all, then the
//   feed-forward adds, row by row.
// Reset and stalls:
//   Reset clears the counter and marks the buffer used up, so the first
//   request makes a block. A stalled receiver holds out_byte; a new request
//   is taken in the same cycle the pending result leaves.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte
);

	localparam int RND_W = $clog2(DOUBLE_ROUNDS);

	// Configuration
	logic [63:0] key01_q, key23_q, key45_q, key67_q, nonce_low_q;
	logic [31:0] nonce_high_q;
	logic        nonce_long_q;

	// Cipher state
	cc20_pkg::state_t state_q, state_d;
	logic [31:0]      cnt_lo_q, cnt_hi_q;
	logic [6:0]       pos_q;
	cc20_pkg::word_t  words_q [16];
	logic [RND_W-1:0] rnd_q;
	logic [2:0]       step_q;
	logic [7:0]       data_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;

	logic            in_acc;
	logic            need_block;
	logic            last_round;
	logic            rounds_done;
	logic [31:0]     cnt_lo_src, cnt_hi_src;
	cc20_pkg::word_t init_w [16];
	cc20_pkg::word_t ks_word;
	logic [7:0]      ks_byte;
	logic [1:0]      sub;
	logic            diag;
	cc20_pkg::quad_t op_p, op_q, op_r, sum, mix;

	assign in_acc      = in_valid && in_ready;
	assign need_block  = restart || pos_q[6];
	assign last_round  = rnd_q == RND_W'(DOUBLE_ROUNDS - 1);
	assign rounds_done = last_round && (step_q == 3'd7);
	assign sub         = step_q[1:0];
	assign diag        = step_q[2];

	// Counter as seen by the block being set up; restart clears it first
	assign cnt_lo_src = (state_q == cc20_pkg::S_IDLE && restart) ? 32'd0 : cnt_lo_q;
	assign cnt_hi_src = (state_q == cc20_pkg::S_IDLE && restart) ? 32'd0 : cnt_hi_q;

	// Block input words
	always_comb begin
		init_w[0]  = cc20_pkg::SIGMA_0;
		init_w[1]  = cc20_pkg::SIGMA_1;
		init_w[2]  = cc20_pkg::SIGMA_2;
		init_w[3]  = cc20_pkg::SIGMA_3;
		init_w[4]  = key01_q[31:0];
		init_w[5]  = key01_q[63:32];
		init_w[6]  = key23_q[31:0];
		init_w[7]  = key23_q[63:32];
		init_w[8]  = key45_q[31:0];
		init_w[9]  = key45_q[63:32];
		init_w[10] = key67_q[31:0];
		init_w[11] = key67_q[63:32];
		init_w[12] = cnt_lo_src;
		if (nonce_long_q) begin
			// counter carry still lands in word 13
			init_w[13] = nonce_low_q[31:0] + cnt_hi_src;
			init_w[14] = nonce_low_q[63:32];
			init_w[15] = nonce_high_q;
		end else begin
			init_w[13] = cnt_hi_src;
			init_w[14] = nonce_low_q[31:0];
			init_w[15] = nonce_low_q[63:32];
		end
	end

	// Keystream byte at the current position
	assign ks_word = words_q[pos_q[5:2]];
	always_comb begin
		case (pos_q[1:0])
			2'd0:    ks_byte = ks_word[7:0];
			2'd1:    ks_byte = ks_word[15:8];
			2'd2:    ks_byte = ks_word[23:16];
			default: ks_byte = ks_word[31:24];
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cc20_pkg::S_IDLE: begin
				if (in_acc && need_block) state_d = cc20_pkg::S_ROUND;
			end
			cc20_pkg::S_ROUND: begin
				if (rounds_done) state_d = cc20_pkg::S_FINAL;
			end
			cc20_pkg::S_FINAL: begin
				if (sub == 2'd3) state_d = cc20_pkg::S_IDLE;
			end
			default: state_d = cc20_pkg::S_IDLE;
		endcase
	end

	// Outputs and step unit operand selection
	always_comb begin
		in_ready = 1'b0;
		op_p     = '0;
		op_q     = '0;
		op_r     = '0;
		unique case (state_q)
			cc20_pkg::S_IDLE: begin
				in_ready = !out_valid_q || out_ready;
			end
			cc20_pkg::S_ROUND: begin
				for (int l = 0; l < 4; l++) begin
					if (!sub[0]) begin
						// a += b; d = rotl(d ^ a)
						op_p[l] = words_q[cc20_pkg::lane_idx(2'd0, 2'(l), diag)];
						op_q[l] = words_q[cc20_pkg::lane_idx(2'd1, 2'(l), diag)];
						op_r[l] = words_q[cc20_pkg::lane_idx(2'd3, 2'(l), diag)];
					end else begin
						// c += d; b = rotl(b ^ c)
						op_p[l] = words_q[cc20_pkg::lane_idx(2'd2, 2'(l), diag)];
						op_q[l] = words_q[cc20_pkg::lane_idx(2'd3, 2'(l), diag)];
						op_r[l] = words_q[cc20_pkg::lane_idx(2'd1, 2'(l), diag)];
					end
				end
			end
			cc20_pkg::S_FINAL: begin
				// feed-forward: one row of four words per cycle
				for (int l = 0; l < 4; l++) begin
					op_p[l] = words_q[{sub, 2'(l)}];
					op_q[l] = init_w[{sub, 2'(l)}];
				end
			end
			default: ;
		endcase
	end

	cc20_step_unit u_step (
		.sub  (sub),
		.op_p (op_p),
		.op_q (op_q),
		.op_r (op_r),
		.sum  (sum),
		.mix  (mix)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key01_q      <= '0;
			key23_q      <= '0;
			key45_q      <= '0;
			key67_q      <= '0;
			nonce_low_q  <= '0;
			nonce_high_q <= '0;
			nonce_long_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				cc20_pkg::REG_KEY_01:     key01_q      <= cfg_data;
				cc20_pkg::REG_KEY_23:     key23_q      <= cfg_data;
				cc20_pkg::REG_KEY_45:     key45_q      <= cfg_data;
				cc20_pkg::REG_KEY_67:     key67_q      <= cfg_data;
				cc20_pkg::REG_NONCE_LOW:  nonce_low_q  <= cfg_data;
				cc20_pkg::REG_NONCE_HIGH: nonce_high_q <= cfg_data[31:0];
				cc20_pkg::REG_NONCE_LONG: nonce_long_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cc20_pkg::S_IDLE;
			cnt_lo_q    <= '0;
			cnt_hi_q    <= '0;
			pos_q       <= 7'd64;
			rnd_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				cc20_pkg::S_IDLE: begin
					if (in_acc) begin
						if (need_block) begin
							// drop the old block and counter on restart
							cnt_lo_q <= cnt_lo_src;
							cnt_hi_q <= cnt_hi_src;
							rnd_q    <= '0;
							step_q   <= '0;
						end else begin
							pos_q <= pos_q + 7'd1;
						end
					end
					// raise on a buffered byte, drop once the receiver takes it
					if (in_acc && !need_block) out_valid_q <= 1'b1;
					else if (out_ready)        out_valid_q <= 1'b0;
				end
				cc20_pkg::S_ROUND: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) rnd_q <= rnd_q + RND_W'(1);
				end
				cc20_pkg::S_FINAL: begin
					step_q <= step_q + 3'd1;
					if (sub == 2'd3) begin
						// word 0 is final by now: emit the first byte
						out_valid_q <= 1'b1;
						pos_q       <= 7'd1;
						cnt_lo_q    <= cnt_lo_q + 32'd1;
						if (cnt_lo_q == 32'hFFFF_FFFF) cnt_hi_q <= cnt_hi_q + 32'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload: working words, held data byte, output byte
	always_ff @(posedge clk) begin
		unique case (state_q)
			cc20_pkg::S_IDLE: begin
				if (in_acc) begin
					data_q <= data_byte;
					if (need_block) begin
						for (int i = 0; i < 16; i++) words_q[i] <= init_w[i];
					end else begin
						out_byte_q <= data_byte ^ ks_byte;
					end
				end
			end
			cc20_pkg::S_ROUND: begin
				for (int l = 0; l < 4; l++) begin
					if (!sub[0]) begin
						words_q[cc20_pkg::lane_idx(2'd0, 2'(l), diag)] <= sum[l];
						words_q[cc20_pkg::lane_idx(2'd3, 2'(l), diag)] <= mix[l];
					end else begin
						words_q[cc20_pkg::lane_idx(2'd2, 2'(l), diag)] <= sum[l];
						words_q[cc20_pkg::lane_idx(2'd1, 2'(l), diag)] <= mix[l];
					end
				end
			end
			cc20_pkg::S_FINAL: begin
				for (int l = 0; l < 4; l++) words_q[{sub, 2'(l)}] <= sum[l];
				if (sub == 2'd3) out_byte_q <= data_q ^ words_q[0][7:0];
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_block_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && need_block |=> !in_ready && !out_valid)
		else $error("block generation did not hold off requests");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 7'd64)
		else $error("byte position beyond buffer");

	a_round_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cc20_pkg::S_ROUND |-> !out_valid_q)
		else $error("result pending during rounds");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_acc) || $past(state_q == cc20_pkg::S_FINAL))
		else $error("result without request or finished block");

endmodule
